>>> rtl/udcm_pkg.sv
// ============================================================================
// udcm_pkg: shared types and constants of the uniform draw to momentum block
// Widths, register indexes, CORDIC arctangent table and the output clamp.
// ============================================================================
package udcm_pkg;

	// default binary angle resolution, 2^ANGLE_BITS per full turn
	localparam int ANGLE_BITS_DEF = 16;

	// field widths
	localparam int DRAW_W = 31;
	localparam int MOM_W  = 16;
	localparam int OUT_W  = 17;

	// angles are worked in 32-bit turns
	localparam int TURN_W = 32;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 30;
	localparam int CS_W         = 33;
	localparam int TRIG_W       = 32;
	localparam logic signed [CS_W-1:0] CORDIC_X0 = 33'sd652032874;

	// sin/cos unit latency: fold stage, one stage per iteration, sign stage
	localparam int SC_LAT = CORDIC_STEPS + 2;

	// arctangent of 2^-i in 2^32-per-turn units
	localparam logic [TURN_W-1:0] ATAN_TURN32 [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
		32'd20,        32'd10,        32'd5,         32'd3,        32'd1
	};

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MOM_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOM_HIGH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POLAR_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POLAR_HIGH   = 3'd5;

	// reset values of the momentum bounds (0.1 and 6.0 GeV/c in Q4.12)
	localparam logic [MOM_W-1:0] MOM_LOW_RST  = 16'd410;
	localparam logic [MOM_W-1:0] MOM_HIGH_RST = 16'd24576;

	// sideband that rides along the sin/cos pipeline
	typedef struct packed {
		logic             vld;
		logic [MOM_W-1:0] mom;
	} udcm_side_t;

	// config data width: widest register
	function automatic int cfg_w(int ab);
		return (ab + 1 > MOM_W) ? ab + 1 : MOM_W;
	endfunction

	// clamp a rounded component to +/-65535
	function automatic logic signed [OUT_W-1:0] sat_out(logic signed [OUT_W+1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > 19'sd65535)
			r = 17'sd65535;
		else if (v < -19'sd65535)
			r = -17'sd65535;
		else
			r = $signed(v[OUT_W-1:0]);
		return r;
	endfunction

endpackage

>>> rtl/uniform_draw_to_cartesian_momentum.sv
// ============================================================================
// uniform_draw_to_cartesian_momentum: photon momentum from three draws
// Maps three 31-bit uniform draws into momentum, azimuth and polar ranges and
// converts to Cartesian components px, py, pz plus energy, in Q4.12.
// ============================================================================
// Usage:
//   Input beat: draw_mom, draw_azimuth, draw_polar are taken at a rising edge
//   with start high and busy low. busy stays low, so a beat may be taken in
//   every cycle; one result comes out per beat.
//   Result beat: done is high for one cycle with mom_x, mom_y, mom_z and
//   energy. The receiver cannot stall; results are never held back.
//   Pipeline: a beat passes one range-map stage, 32 stages of sine/cosine
//   (fold, one per CORDIC iteration, sign), two multiply stages and the
//   output clamp stage, whose register drives done and the result.
//   Throughput: one item per clock.
//   Configuration: six bound registers written over cfg_valid/cfg_ready
//   with cfg_index and cfg_data; cfg_ready is always high. Writes belong to
//   idle periods. Indexes above five are dropped.
//   Reset: arst_n clears all beats in flight and loads the default bounds
//   (0.1 to 6.0 GeV/c, full azimuth turn, polar half turn).
// ============================================================================
module uniform_draw_to_cartesian_momentum #(
	parameter int ANGLE_BITS = udcm_pkg::ANGLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// item channel
	input  logic                                         start,
	output logic                                         busy,
	input  logic [udcm_pkg::DRAW_W-1:0]                  draw_mom,
	input  logic [udcm_pkg::DRAW_W-1:0]                  draw_azimuth,
	input  logic [udcm_pkg::DRAW_W-1:0]                  draw_polar,
	// configuration channel
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [udcm_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  logic [udcm_pkg::cfg_w(ANGLE_BITS)-1:0]       cfg_data,
	// result channel
	output logic                                         done,
	output logic signed [udcm_pkg::OUT_W-1:0]            mom_x,
	output logic signed [udcm_pkg::OUT_W-1:0]            mom_y,
	output logic signed [udcm_pkg::OUT_W-1:0]            mom_z,
	output logic [udcm_pkg::MOM_W-1:0]                   energy
);

	localparam int AB   = ANGLE_BITS;
	localparam int MW   = udcm_pkg::MOM_W;
	localparam int OW   = udcm_pkg::OUT_W;
	localparam int TGW  = udcm_pkg::TRIG_W;
	localparam int DW   = udcm_pkg::DRAW_W;
	// range-map widths: signed difference and product
	localparam int DM_W = MW + 1;
	localparam int PM_W = DW + 1 + DM_W;
	localparam int DA_W = AB + 2;
	localparam int PA_W = DW + 1 + DA_W;
	localparam int DP_W = AB + 1;
	localparam int PP_W = DW + 1 + DP_W;
	// second multiply widths
	localparam int PF_W = 2 * TGW;
	localparam int PO_W = MW + 1 + TGW;
	localparam int RND  = 30;

	// configuration registers
	logic [MW-1:0] mom_low_q;
	logic [MW-1:0] mom_high_q;
	logic [AB:0]   azimuth_low_q;
	logic [AB:0]   azimuth_high_q;
	logic [AB-1:0] polar_low_q;
	logic [AB-1:0] polar_high_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom_low_q      <= udcm_pkg::MOM_LOW_RST;
			mom_high_q     <= udcm_pkg::MOM_HIGH_RST;
			azimuth_low_q  <= '0;
			azimuth_high_q <= {1'b1, {AB{1'b0}}};
			polar_low_q    <= '0;
			polar_high_q   <= {1'b1, {(AB-1){1'b0}}};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				udcm_pkg::REG_MOM_LOW:      mom_low_q      <= cfg_data[MW-1:0];
				udcm_pkg::REG_MOM_HIGH:     mom_high_q     <= cfg_data[MW-1:0];
				udcm_pkg::REG_AZIMUTH_LOW:  azimuth_low_q  <= cfg_data[AB:0];
				udcm_pkg::REG_AZIMUTH_HIGH: azimuth_high_q <= cfg_data[AB:0];
				udcm_pkg::REG_POLAR_LOW:    polar_low_q    <= cfg_data[AB-1:0];
				udcm_pkg::REG_POLAR_HIGH:   polar_high_q   <= cfg_data[AB-1:0];
				default: ;
			endcase
		end
	end

	// ---- stage 1: affine range map, low + floor(draw * (high - low) / 2^31)
	logic signed [DM_W-1:0] diff_mom;
	logic signed [DA_W-1:0] diff_az;
	logic signed [DP_W-1:0] diff_pol;
	logic signed [PM_W-1:0] prod_mom;
	logic signed [PA_W-1:0] prod_az;
	logic signed [PP_W-1:0] prod_pol;
	logic signed [DM_W:0]   map_mom;
	logic signed [DA_W:0]   map_az;
	logic signed [DP_W:0]   map_pol;

	assign diff_mom = $signed({1'b0, mom_high_q}) - $signed({1'b0, mom_low_q});
	assign diff_az  = $signed({1'b0, azimuth_high_q}) - $signed({1'b0, azimuth_low_q});
	assign diff_pol = $signed({1'b0, polar_high_q}) - $signed({1'b0, polar_low_q});

	assign prod_mom = $signed({1'b0, draw_mom}) * diff_mom;
	assign prod_az  = $signed({1'b0, draw_azimuth}) * diff_az;
	assign prod_pol = $signed({1'b0, draw_polar}) * diff_pol;

	assign map_mom = $signed({2'b00, mom_low_q}) + $signed(prod_mom[PM_W-1:DW]);
	assign map_az  = $signed({2'b00, azimuth_low_q}) + $signed(prod_az[PA_W-1:DW]);
	assign map_pol = $signed({2'b00, polar_low_q}) + $signed(prod_pol[PP_W-1:DW]);

	logic          vld_s1;
	logic [MW-1:0] mom_s1;
	logic [AB-1:0] phi_s1;
	logic [AB-1:0] theta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	// angles keep only the bits inside one turn
	always_ff @(posedge clk) begin
		mom_s1   <= map_mom[MW-1:0];
		phi_s1   <= map_az[AB-1:0];
		theta_s1 <= map_pol[AB-1:0];
	end

	// ---- stages 2..33: sine and cosine of azimuth (lane a) and polar (lane b)
	udcm_pkg::udcm_side_t       sc_in;
	udcm_pkg::udcm_side_t       sc_out;
	logic signed [TGW-1:0]      sin_phi;
	logic signed [TGW-1:0]      cos_phi;
	logic signed [TGW-1:0]      sin_theta;
	logic signed [TGW-1:0]      cos_theta;

	assign sc_in.vld = vld_s1;
	assign sc_in.mom = mom_s1;

	udcm_sincos #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (sc_in),
		.ang_a    (phi_s1),
		.ang_b    (theta_s1),
		.side_out (sc_out),
		.sin_a    (sin_phi),
		.cos_a    (cos_phi),
		.sin_b    (sin_theta),
		.cos_b    (cos_theta)
	);

	// ---- stage 34: transverse factors, Q60 products rounded to Q30
	logic signed [PF_W-1:0] fx_full;
	logic signed [PF_W-1:0] fy_full;

	assign fx_full = sin_theta * cos_phi + $signed(PF_W'(1) <<< (RND - 1));
	assign fy_full = sin_theta * sin_phi + $signed(PF_W'(1) <<< (RND - 1));

	logic                  vld_s34;
	logic [MW-1:0]         mom_s34;
	logic signed [TGW-1:0] fx_s34;
	logic signed [TGW-1:0] fy_s34;
	logic signed [TGW-1:0] fz_s34;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s34 <= 1'b0;
		else
			vld_s34 <= sc_out.vld;
	end

	always_ff @(posedge clk) begin
		mom_s34 <= sc_out.mom;
		fx_s34  <= $signed(fx_full[RND+TGW-1:RND]);
		fy_s34  <= $signed(fy_full[RND+TGW-1:RND]);
		fz_s34  <= cos_theta;
	end

	// ---- stage 35: scale by momentum, Q30 factor to Q12
	logic signed [PO_W-1:0] px_full;
	logic signed [PO_W-1:0] py_full;
	logic signed [PO_W-1:0] pz_full;

	assign px_full = $signed({1'b0, mom_s34}) * fx_s34 + $signed(PO_W'(1) <<< (RND - 1));
	assign py_full = $signed({1'b0, mom_s34}) * fy_s34 + $signed(PO_W'(1) <<< (RND - 1));
	assign pz_full = $signed({1'b0, mom_s34}) * fz_s34 + $signed(PO_W'(1) <<< (RND - 1));

	logic                 vld_s35;
	logic [MW-1:0]        mom_s35;
	logic signed [OW+1:0] px_s35;
	logic signed [OW+1:0] py_s35;
	logic signed [OW+1:0] pz_s35;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s35 <= 1'b0;
		else
			vld_s35 <= vld_s34;
	end

	always_ff @(posedge clk) begin
		mom_s35 <= mom_s34;
		px_s35  <= $signed(px_full[RND+OW+1:RND]);
		py_s35  <= $signed(py_full[RND+OW+1:RND]);
		pz_s35  <= $signed(pz_full[RND+OW+1:RND]);
	end

	// ---- stage 36: clamp and present the result beat
	logic                 done_s36;
	logic [MW-1:0]        energy_s36;
	logic signed [OW-1:0] mom_x_s36;
	logic signed [OW-1:0] mom_y_s36;
	logic signed [OW-1:0] mom_z_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s36 <= 1'b0;
		else
			done_s36 <= vld_s35;
	end

	always_ff @(posedge clk) begin
		energy_s36 <= mom_s35;
		mom_x_s36  <= udcm_pkg::sat_out(px_s35);
		mom_y_s36  <= udcm_pkg::sat_out(py_s35);
		mom_z_s36  <= udcm_pkg::sat_out(pz_s35);
	end

	assign done   = done_s36;
	assign energy = energy_s36;
	assign mom_x  = mom_x_s36;
	assign mom_y  = mom_y_s36;
	assign mom_z  = mom_z_s36;

	// ---- checks
	// a beat leaving the sin/cos unit is one that the range map stage handed to it
	a_sc_align: assert property (@(posedge clk) disable iff (!arst_n)
		sc_out.vld |-> $past(vld_s1, udcm_pkg::SC_LAT))
		else $error("sin/cos sideband out of step with the range map stage");

	// energy matches the momentum mapped for the same beat
	a_energy_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (energy == $past(mom_s1, udcm_pkg::SC_LAT + 3)))
		else $error("energy does not belong to the result beat");

	// clamp keeps components symmetric, never the most negative code
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mom_x != -17'sd65536 && mom_y != -17'sd65536 && mom_z != -17'sd65536))
		else $error("momentum component escaped the clamp");

endmodule

>>> rtl/udcm_sincos.sv
// ============================================================================
// udcm_sincos: pipelined sine/cosine of two binary angles
// Folds each angle into +/- a quarter turn, runs a rotation-mode CORDIC with
// one iteration per stage and restores the sign. Carries a sideband beat.
// ============================================================================
module udcm_sincos #(
	parameter int ANGLE_BITS = udcm_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  udcm_pkg::udcm_side_t                side_in,
	input  logic [ANGLE_BITS-1:0]               ang_a,
	input  logic [ANGLE_BITS-1:0]               ang_b,
	output udcm_pkg::udcm_side_t                side_out,
	output logic signed [udcm_pkg::TRIG_W-1:0]  sin_a,
	output logic signed [udcm_pkg::TRIG_W-1:0]  cos_a,
	output logic signed [udcm_pkg::TRIG_W-1:0]  sin_b,
	output logic signed [udcm_pkg::TRIG_W-1:0]  cos_b
);

	localparam int NS = udcm_pkg::CORDIC_STEPS;
	localparam int CW = udcm_pkg::CS_W;
	localparam int TW = udcm_pkg::TURN_W;

	// per-lane stage registers, index 0 is the fold stage
	logic signed [CW-1:0] x_s [2][NS+1];
	logic signed [CW-1:0] y_s [2][NS+1];
	logic signed [CW-1:0] z_s [2][NS+1];
	logic                 neg_s [2][NS+1];

	// final sign-restored outputs
	logic signed [udcm_pkg::TRIG_W-1:0] sn_s [2];
	logic signed [udcm_pkg::TRIG_W-1:0] cs_s [2];

	// sideband, one entry per stage plus the sign stage
	logic                       vld_s [NS+2];
	logic [udcm_pkg::MOM_W-1:0] mom_s [NS+2];

	logic [ANGLE_BITS-1:0] ang_in [2];

	assign ang_in[0] = ang_a;
	assign ang_in[1] = ang_b;

	genvar l, k;

	generate
		for (l = 0; l < 2; l++) begin : g_lane
			logic [TW-1:0]        a32;
			logic signed [TW-1:0] zs;
			logic                 big;
			logic [TW-1:0]        zf;
			logic signed [CW-1:0] nx;
			logic signed [CW-1:0] ny;

			// scale to a 32-bit turn and fold by a half turn
			assign a32 = {ang_in[l], {(TW-ANGLE_BITS){1'b0}}};
			assign zs  = $signed(a32);
			assign big = (zs > 32'sh4000_0000) || (zs < -32'sh4000_0000);
			assign zf  = big ? {~a32[TW-1], a32[TW-2:0]} : a32;

			always_ff @(posedge clk) begin
				x_s[l][0]   <= udcm_pkg::CORDIC_X0;
				y_s[l][0]   <= '0;
				z_s[l][0]   <= $signed({{(CW-TW){zf[TW-1]}}, zf});
				neg_s[l][0] <= big;
			end

			// one CORDIC iteration per stage
			for (k = 1; k <= NS; k++) begin : g_iter
				logic signed [CW-1:0] dx;
				logic signed [CW-1:0] dy;
				logic signed [CW-1:0] at;

				assign dx = y_s[l][k-1] >>> (k-1);
				assign dy = x_s[l][k-1] >>> (k-1);
				assign at = $signed({{(CW-TW){1'b0}}, udcm_pkg::ATAN_TURN32[k-1]});

				always_ff @(posedge clk) begin
					if (!z_s[l][k-1][CW-1]) begin
						x_s[l][k] <= x_s[l][k-1] - dx;
						y_s[l][k] <= y_s[l][k-1] + dy;
						z_s[l][k] <= z_s[l][k-1] - at;
					end else begin
						x_s[l][k] <= x_s[l][k-1] + dx;
						y_s[l][k] <= y_s[l][k-1] - dy;
						z_s[l][k] <= z_s[l][k-1] + at;
					end
					neg_s[l][k] <= neg_s[l][k-1];
				end
			end

			// undo the half-turn fold
			assign nx = neg_s[l][NS] ? -x_s[l][NS] : x_s[l][NS];
			assign ny = neg_s[l][NS] ? -y_s[l][NS] : y_s[l][NS];

			always_ff @(posedge clk) begin
				cs_s[l] <= $signed(nx[udcm_pkg::TRIG_W-1:0]);
				sn_s[l] <= $signed(ny[udcm_pkg::TRIG_W-1:0]);
			end
		end
	endgenerate

	// sideband valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS + 2; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= side_in.vld;
			for (int i = 1; i < NS + 2; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// sideband payload chain
	always_ff @(posedge clk) begin
		mom_s[0] <= side_in.mom;
		for (int i = 1; i < NS + 2; i++)
			mom_s[i] <= mom_s[i-1];
	end

	assign side_out.vld = vld_s[NS+1];
	assign side_out.mom = mom_s[NS+1];
	assign sin_a = sn_s[0];
	assign cos_a = cs_s[0];
	assign sin_b = sn_s[1];
	assign cos_b = cs_s[1];

endmodule
